FILE: rtl/sha1_stream_hasher_defines.svh
// Assertion helpers shared by the hasher modules.
// Both expect clk and arst_n in the enclosing scope.
`ifndef SHA1_STREAM_HASHER_DEFINES_SVH
`define SHA1_STREAM_HASHER_DEFINES_SVH

// Consequent checked in the same cycle.
`define SHA1S_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SHA1S_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/sha1s_pkg.sv
`default_nettype none
package sha1s_pkg;

	localparam int BYTE_W       = 8;
	localparam int WORD_W       = 32;
	localparam int BLK_WORDS    = 16;
	localparam int DIGEST_WORDS = 5;
	localparam int IDX_W        = 3;
	localparam int CNT_W        = 61;
	localparam int ROUND_W      = 7;
	localparam int ROUNDS       = 80;

	localparam int LEN_HI_IDX = BLK_WORDS - 2;
	localparam int LEN_LO_IDX = BLK_WORDS - 1;

	// byte position from which the length no longer fits in the block
	localparam logic [5:0] PAD_LIMIT = 6'd56;
	localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h80;

	localparam logic [WORD_W-1:0] H_INIT [DIGEST_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [WORD_W-1:0] K_R0 = 32'h5A827999;
	localparam logic [WORD_W-1:0] K_R1 = 32'h6ED9EBA1;
	localparam logic [WORD_W-1:0] K_R2 = 32'h8F1BBCDC;
	localparam logic [WORD_W-1:0] K_R3 = 32'hCA62C1D6;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [BLK_WORDS-1:0][WORD_W-1:0] words;
		logic                             last_blk;
	} blk_t;

endpackage
`default_nettype wire

FILE: rtl/sha1s_if.sv
`default_nettype none
interface sha1s_msg_if;
	import sha1s_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              has_byte;
	logic              end_of_message;

	modport source (output valid, data_byte, has_byte, end_of_message, input ready);
	modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha1s_dig_if;
	import sha1s_pkg::*;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] digest_word;
	logic [IDX_W-1:0]  word_index;
	logic              last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

FILE: rtl/sha1s_front.sv
`default_nettype none
module sha1s_front (
	input  logic             clk,
	input  logic             arst_n,
	sha1s_msg_if.sink        msg,
	output logic             push_valid,
	input  logic             push_ready,
	output sha1s_pkg::blk_t  push_blk
);
	import sha1s_pkg::*;

	typedef enum logic [2:0] {
		F_FILL, F_PUSH_DATA, F_PAD, F_PUSH_EXTRA, F_PUSH_FINAL
	} fstate_t;

	fstate_t                          state_q;
	logic [CNT_W-1:0]                 count_q;
	logic                             eom_pend_q;
	logic [BLK_WORDS-1:0][WORD_W-1:0] buf_q;

	logic [5:0]  pos;
	logic [3:0]  wi;
	logic [4:0]  lane_sh;
	logic [63:0] bit_len;
	logic        accept;

	assign pos     = count_q[5:0];
	assign wi      = pos[5:2];
	assign lane_sh = {~pos[1:0], 3'b000};
	assign bit_len = {count_q, 3'b000};

	assign msg.ready = (state_q == F_FILL);
	assign accept    = msg.valid && msg.ready;

	assign push_valid = (state_q == F_PUSH_DATA) || (state_q == F_PUSH_EXTRA) ||
		(state_q == F_PUSH_FINAL);

	always_comb begin
		push_blk.words    = buf_q;
		push_blk.last_blk = 1'b0;
		if (state_q == F_PUSH_FINAL) begin
			push_blk.words[LEN_HI_IDX] = bit_len[63:32];
			push_blk.words[LEN_LO_IDX] = bit_len[31:0];
			push_blk.last_blk          = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_FILL;
			count_q    <= '0;
			eom_pend_q <= 1'b0;
		end else begin
			case (state_q)
				F_FILL: begin
					if (accept) begin
						eom_pend_q <= msg.end_of_message;
						if (msg.has_byte) begin
							count_q <= count_q + CNT_W'(1);
						end
						if (msg.has_byte && (pos == 6'd63)) begin
							state_q <= F_PUSH_DATA;
						end else if (msg.end_of_message) begin
							state_q <= F_PAD;
						end
					end
				end
				F_PUSH_DATA: begin
					if (push_ready) begin
						state_q <= eom_pend_q ? F_PAD : F_FILL;
					end
				end
				F_PAD: begin
					state_q <= (pos >= PAD_LIMIT) ? F_PUSH_EXTRA : F_PUSH_FINAL;
				end
				F_PUSH_EXTRA: begin
					if (push_ready) begin
						state_q <= F_PUSH_FINAL;
					end
				end
				F_PUSH_FINAL: begin
					if (push_ready) begin
						count_q <= '0;
						state_q <= F_FILL;
					end
				end
				default: begin
					state_q <= F_FILL;
				end
			endcase
		end
	end

	// block buffer; a byte at lane 0 overwrites the word, so later lanes OR into zeros
	always_ff @(posedge clk) begin
		if (accept && msg.has_byte) begin
			if (pos[1:0] == 2'd0) begin
				buf_q[wi] <= {msg.data_byte, 24'h0};
			end else begin
				buf_q[wi][lane_sh +: BYTE_W] <= msg.data_byte;
			end
		end else if (state_q == F_PAD) begin
			for (int j = 0; j < BLK_WORDS; j++) begin
				if (4'(j) > wi) begin
					buf_q[j] <= '0;
				end
			end
			if (pos[1:0] == 2'd0) begin
				buf_q[wi] <= {PAD_BYTE, 24'h0};
			end else begin
				buf_q[wi][lane_sh +: BYTE_W] <= PAD_BYTE;
			end
		end else if ((state_q == F_PUSH_EXTRA) && push_ready) begin
			buf_q <= '0;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/sha1s_blk_queue.sv
`default_nettype none
`include "sha1_stream_hasher_defines.svh"
module sha1s_blk_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  sha1s_pkg::blk_t  push_blk,
	output logic             pop_valid,
	input  logic             pop_ready,
	output sha1s_pkg::blk_t  pop_blk
);
	import sha1s_pkg::*;

	blk_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_blk    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_blk;
		end
	end

	`SHA1S_ASSERT_NEXT(a_push_not_empty, do_push, count_q != '0, "queue empty after a push")

endmodule
`default_nettype wire

FILE: rtl/sha1s_core.sv
`default_nettype none
`include "sha1_stream_hasher_defines.svh"
module sha1s_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  sha1s_pkg::blk_t  pop_blk,
	sha1s_dig_if.source      digest
);
	import sha1s_pkg::*;

	typedef enum logic [1:0] {B_IDLE, B_ROUND, B_ADD, B_OUT} bstate_t;

	localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

	bstate_t           state_q;
	logic [ROUND_W-1:0] round_q;
	logic              last_q;
	logic [WORD_W-1:0] chain_q [DIGEST_WORDS];
	logic [WORD_W-1:0] a_q, b_q, c_q, d_q, e_q;
	logic [WORD_W-1:0] sched_q [BLK_WORDS];
	logic              out_valid_q;
	logic [WORD_W-1:0] out_word_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic              out_last_q;

	logic [WORD_W-1:0] w_mix, w, f, k, t;
	logic [IDX_W-1:0]  idx_nxt;
	logic              do_pop;
	logic              out_take;

	assign pop_ready = (state_q == B_IDLE);
	assign do_pop    = pop_valid && pop_ready;
	assign out_take  = out_valid_q && digest.ready;
	assign idx_nxt   = out_idx_q + IDX_W'(1);

	assign digest.valid       = out_valid_q;
	assign digest.digest_word = out_word_q;
	assign digest.word_index  = out_idx_q;
	assign digest.last_word   = out_last_q;

	// window holds W[r-16..r-1] once the first sixteen words have rotated through
	assign w_mix = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
	assign w     = (round_q < ROUND_W'(BLK_WORDS)) ? sched_q[0] : {w_mix[30:0], w_mix[31]};

	always_comb begin
		if (round_q inside {[7'd0:7'd19]}) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K_R0;
		end else if (round_q inside {[7'd20:7'd39]}) begin
			f = b_q ^ c_q ^ d_q;
			k = K_R1;
		end else if (round_q inside {[7'd40:7'd59]}) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K_R2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K_R3;
		end
	end

	assign t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			round_q     <= '0;
			last_q      <= 1'b0;
			chain_q     <= H_INIT;
			a_q         <= '0;
			b_q         <= '0;
			c_q         <= '0;
			d_q         <= '0;
			e_q         <= '0;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
			out_idx_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (do_pop) begin
						a_q     <= chain_q[0];
						b_q     <= chain_q[1];
						c_q     <= chain_q[2];
						d_q     <= chain_q[3];
						e_q     <= chain_q[4];
						last_q  <= pop_blk.last_blk;
						round_q <= '0;
						state_q <= B_ROUND;
					end
				end
				B_ROUND: begin
					a_q     <= t;
					b_q     <= a_q;
					c_q     <= {b_q[1:0], b_q[31:2]};
					d_q     <= c_q;
					e_q     <= d_q;
					round_q <= round_q + ROUND_W'(1);
					if (round_q == LAST_ROUND) begin
						state_q <= B_ADD;
					end
				end
				B_ADD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q;
					if (last_q) begin
						out_valid_q <= 1'b1;
						out_word_q  <= chain_q[0] + a_q;
						out_idx_q   <= '0;
						out_last_q  <= 1'b0;
						state_q     <= B_OUT;
					end else begin
						state_q <= B_IDLE;
					end
				end
				B_OUT: begin
					if (out_take) begin
						if (out_last_q) begin
							out_valid_q <= 1'b0;
							chain_q     <= H_INIT;
							state_q     <= B_IDLE;
						end else begin
							out_idx_q  <= idx_nxt;
							out_word_q <= chain_q[idx_nxt];
							out_last_q <= (idx_nxt == IDX_W'(DIGEST_WORDS - 1));
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			for (int i = 0; i < BLK_WORDS; i++) begin
				sched_q[i] <= pop_blk.words[i];
			end
		end else if (state_q == B_ROUND) begin
			for (int i = 0; i < BLK_WORDS - 1; i++) begin
				sched_q[i] <= sched_q[i + 1];
			end
			sched_q[BLK_WORDS-1] <= w;
		end
	end

	`SHA1S_ASSERT_NEXT(a_round_to_add, (state_q == B_ROUND) && (round_q == LAST_ROUND), state_q == B_ADD, "round 79 not followed by add")
	`SHA1S_ASSERT_NEXT(a_chain_restored, out_take && out_last_q, chain_q[0] == H_INIT[0], "chain not restored after digest")
	`SHA1S_ASSERT_IMP(a_valid_in_out, out_valid_q, state_q == B_OUT, "digest valid outside output phase")

endmodule
`default_nettype wire

FILE: rtl/sha1_stream_hasher.sv
// SHA-1 stream hasher.
// msg (sink): one request per message byte; has_byte marks a real byte and
//   end_of_message closes the message, with or without a byte of its own.
// digest (source): five requests per message, word_index 0 (most significant)
//   to 4, last_word on the fifth.
// Throughput: bytes are taken one a cycle while the front is filling a block
//   and the two-block queue has room. The core loads a block, runs 80 rounds
//   on one shared round unit, adds the chain and only then takes a new block.
// End of message: the front pads, pushes an extra padding block when the
//   length does not fit and then the final block with the length; the first
//   digest word is registered in the chain add after the last pending block,
//   and the words follow one a cycle while digest.ready is high.
// Reset: chain value back to the initial constants, byte count cleared, queue
//   emptied; no clearing pass is needed.
// Stall: a waiting digest word holds; the core stops taking blocks, the front
//   keeps filling the queue, dropping msg.ready when it and its block are full.
`default_nettype none
module sha1_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	sha1s_msg_if.sink   msg,
	sha1s_dig_if.source digest
);
	import sha1s_pkg::*;

	// front to queue
	logic push_valid;
	logic push_ready;
	blk_t push_blk;

	// queue to core
	logic pop_valid;
	logic pop_ready;
	blk_t pop_blk;

	// byte packing and padding
	sha1s_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_blk   (push_blk)
	);

	// decouples filling from compression
	sha1s_blk_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_blk   (push_blk),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_blk    (pop_blk)
	);

	// compression rounds, chain value and digest output
	sha1s_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_blk   (pop_blk),
		.digest    (digest)
	);

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`default_nettype none
module testbench;
	import sha1s_pkg::*;

	// Per-word digest record, as it leaves the digest channel.
	typedef struct {
		logic [WORD_W-1:0] word;
		logic [IDX_W-1:0]  index;
		logic              last;
	} digest_rec_t;

	// Generous ceiling: all requests with long gaps, at most two blocks through
	// the core per message, and long digest stalls.
	localparam int CYCLE_LIMIT = 300000;
	// Settle time once the last digest word has gone: a two-block pad plus margin.
	localparam int SETTLE_CYCLES = 200;
	localparam int RANDOM_REQUESTS = 70;
	localparam int RANDOM_MESSAGES = 2;

	logic clk;
	logic arst_n;

	sha1s_msg_if msg_ch ();
	sha1s_dig_if dig_ch ();

	sha1_stream_hasher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch.sink),
		.digest (dig_ch.source)
	);

	// Model state: running chain value, block being packed, message length.
	logic [WORD_W-1:0] chain_h [DIGEST_WORDS];
	logic [WORD_W-1:0] blk_w [BLK_WORDS];
	logic [CNT_W-1:0]  msg_bytes;

	digest_rec_t digest_due [$];

	int  mismatches;
	int  cycles;
	int  requests_sent;
	int  messages_sent;
	// Set for stretches where neither side idles.
	bit  no_idle;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [WORD_W-1:0] rotate_left(input logic [WORD_W-1:0] v, input int n);
		return (v << n) | (v >> (WORD_W - n));
	endfunction

	// One full SHA-1 compression of blk_w into chain_h; rolling 16-word schedule.
	function automatic void compress_block();
		logic [WORD_W-1:0] w [BLK_WORDS];
		logic [WORD_W-1:0] a, b, c, d, e, f, k, wr, t;
		w = blk_w;
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (int r = 0; r < ROUNDS; r++) begin
			if (r < 16) begin
				wr = w[r];
			end else begin
				wr = rotate_left(w[(r - 3) & 15] ^ w[(r - 8) & 15] ^
					w[(r - 14) & 15] ^ w[r & 15], 1);
				w[r & 15] = wr;
			end
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = K_R0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K_R1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_R2;
			end else begin
				f = b ^ c ^ d;
				k = K_R3;
			end
			t = rotate_left(a, 5) + f + e + k + wr;
			e = d;
			d = c;
			c = rotate_left(b, 30);
			b = a;
			a = t;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
	endfunction

	// Big-endian byte placement; the first byte of a word overwrites it whole.
	function automatic void place_byte(input logic [5:0] pos, input logic [BYTE_W-1:0] v);
		logic [WORD_W-1:0] lane;
		int sh;
		sh = (3 - int'(pos[1:0])) * 8;
		lane = WORD_W'(v) << sh;
		if (pos[1:0] == 2'd0)
			blk_w[pos[5:2]] = lane;
		else
			blk_w[pos[5:2]] |= lane;
	endfunction

	// Updates the model for one accepted request and queues any digest words.
	function automatic void hash_request(input logic [BYTE_W-1:0] b, input logic has,
		input logic eom);
		logic [5:0]  pos;
		logic [63:0] bit_len;
		digest_rec_t rec;
		if (has) begin
			pos = msg_bytes[5:0];
			place_byte(pos, b);
			msg_bytes = msg_bytes + CNT_W'(1);
			if (pos == 6'd63)
				compress_block();
		end
		if (!eom)
			return;
		pos = msg_bytes[5:0];
		bit_len = {msg_bytes, 3'b000};
		place_byte(pos, PAD_BYTE);
		for (int i = int'(pos) + 1; i < 64; i++)
			place_byte(6'(i), 8'h00);
		// length no longer fits: flush this block, then a block of zeros
		if (pos >= PAD_LIMIT) begin
			compress_block();
			foreach (blk_w[i])
				blk_w[i] = '0;
		end
		blk_w[LEN_HI_IDX] = bit_len[63:32];
		blk_w[LEN_LO_IDX] = bit_len[31:0];
		compress_block();
		for (int i = 0; i < DIGEST_WORDS; i++) begin
			rec.word  = chain_h[i];
			rec.index = IDX_W'(i);
			rec.last  = (i == DIGEST_WORDS - 1);
			digest_due.push_back(rec);
		end
		chain_h = H_INIT;
		msg_bytes = '0;
	endfunction

	// Idle length: mostly short, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Sends one request and returns on the edge at which it is taken. valid is
	// left high so a back-to-back request only changes the payload.
	task automatic send_request(input logic [BYTE_W-1:0] b, input logic has, input logic eom);
		int gap;
		gap = (no_idle || $urandom_range(0, 2) == 0) ? 0 : idle_len();
		if (gap > 0) begin
			msg_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg_ch.valid          <= 1'b1;
		msg_ch.data_byte      <= b;
		msg_ch.has_byte       <= has;
		msg_ch.end_of_message <= eom;
		do @(posedge clk); while (!msg_ch.ready);
		hash_request(b, has, eom);
	endtask

	// Sender holds off until every digest word owed has been taken.
	task automatic hold_until_drained();
		msg_ch.valid <= 1'b0;
		@(posedge clk);
		while (digest_due.size() != 0)
			@(posedge clk);
	endtask

	// A request that neither carries a byte nor ends the message: ignored.
	task automatic send_filler();
		send_request(BYTE_W'($urandom), 1'b0, 1'b0);
	endtask

	task automatic test_empty_message();
		// end request alone, no byte ever sent
		send_request(BYTE_W'($urandom), 1'b0, 1'b1);
	endtask

	task automatic test_byte_with_end();
		// "abc": last byte and end in one request
		send_request(8'h61, 1'b1, 1'b0);
		send_request(8'h62, 1'b1, 1'b0);
		send_request(8'h63, 1'b1, 1'b1);
	endtask

	task automatic test_ignored_requests();
		send_filler();
		send_request(8'h61, 1'b1, 1'b0);
		send_filler();
		send_request(8'h62, 1'b1, 1'b0);
		send_filler();
		send_request(8'hA5, 1'b0, 1'b1);
	endtask

	task automatic test_byte_extremes();
		send_request(8'h00, 1'b1, 1'b0);
		send_request(8'hFF, 1'b1, 1'b0);
		send_request(8'hFF, 1'b0, 1'b1);
		send_request(8'hFF, 1'b1, 1'b1);
		send_request(8'h00, 1'b1, 1'b1);
	endtask

	// Well-formed messages with random content and lengths; padding boundaries
	// (55/56 and 63/64 pending bytes) drawn on purpose now and then.
	task automatic test_random_messages();
		int len;
		int pick;
		logic eom_with_byte;
		while (requests_sent < RANDOM_REQUESTS || messages_sent < RANDOM_MESSAGES) begin
			no_idle = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 7);
			if (messages_sent == 0 || pick == 0) begin
				case ($urandom_range(0, 4))
					0: len = 55;
					1: len = 56;
					2: len = 57;
					3: len = 63;
					default: len = 64;
				endcase
			end else begin
				len = $urandom_range(0, 20);
			end
			eom_with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_filler();
				send_request(BYTE_W'($urandom), 1'b1,
					(i == len - 1) && eom_with_byte);
				requests_sent++;
			end
			if (!eom_with_byte) begin
				send_request(BYTE_W'($urandom), 1'b0, 1'b1);
				requests_sent++;
			end
			messages_sent++;
			if ($urandom_range(0, 3) == 0)
				hold_until_drained();
		end
		no_idle = 1'b0;
	endtask

	// Digest side: checks each taken word against the oldest one owed, then
	// picks the next ready with random stalls.
	initial begin : digest_sink
		int stall_left;
		digest_rec_t want;
		stall_left = 0;
		dig_ch.ready <= 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (dig_ch.valid && dig_ch.ready) begin
				if (digest_due.size() == 0) begin
					$error("digest word %h with no digest owed", dig_ch.digest_word);
					mismatches++;
				end else begin
					want = digest_due.pop_front();
					if (dig_ch.digest_word !== want.word) begin
						$error("digest_word: expected %h, got %h", want.word,
							dig_ch.digest_word);
						mismatches++;
					end
					if (dig_ch.word_index !== want.index) begin
						$error("word_index: expected %0d, got %0d", want.index,
							dig_ch.word_index);
						mismatches++;
					end
					if (dig_ch.last_word !== want.last) begin
						$error("last_word: expected %0b, got %0b", want.last,
							dig_ch.last_word);
						mismatches++;
					end
				end
			end
			if (stall_left > 0) begin
				dig_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				dig_ch.ready <= 1'b1;
				if (!no_idle && $urandom_range(0, 5) == 0)
					stall_left = idle_len();
			end
		end
	end

	initial begin
		mismatches    = 0;
		cycles        = 0;
		requests_sent = 0;
		messages_sent = 0;
		no_idle       = 1'b0;
		chain_h       = H_INIT;
		foreach (blk_w[i])
			blk_w[i] = '0;
		msg_bytes = '0;
		arst_n = 1'b0;
		msg_ch.valid          <= 1'b0;
		msg_ch.data_byte      <= '0;
		msg_ch.has_byte       <= 1'b0;
		msg_ch.end_of_message <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_message();
		test_byte_with_end();
		test_ignored_requests();
		test_byte_extremes();
		hold_until_drained();
		test_random_messages();

		// all requests taken: wait for the last digest, then let the core settle
		msg_ch.valid <= 1'b0;
		@(posedge clk);
		while (digest_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
